@@ sv/prs_pkg.sv @@
// Shared constants and helpers for the tolerant precision/recall scorer.
// No dependencies; imported by prs_div and the top level.
package prs_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int WINDOW_RADIUS = 2;
  localparam int RING_ROWS     = 2 * WINDOW_RADIUS + 1;

  localparam int GEO_W   = 12;                          // config register width
  localparam int COL_W   = $clog2(MAX_WIDTH);           // column index
  localparam int ROW_W   = $clog2(MAX_HEIGHT);          // row index
  localparam int LW_W    = $clog2(MAX_WIDTH + 1);       // latched width
  localparam int LH_W    = $clog2(MAX_HEIGHT + 1);      // latched height, finalize row
  localparam int SC_W    = $clog2(MAX_WIDTH + WINDOW_RADIUS); // sweep counter
  localparam int NY_W    = LH_W + 2;                    // signed neighbor row
  localparam int RING_W  = $clog2(RING_ROWS);
  localparam int ENT_W   = 2;                           // stored entry bits
  localparam int CNT_W   = 23;
  localparam int FRAC_W  = 16;
  localparam int Q_W     = 18;
  localparam int CFG_IDX_W = 1;

  // entry bits
  localparam int EXP_BIT = 0;
  localparam int ACT_BIT = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [7:0]       PIX_POS  = 8'hFF;
  localparam logic [7:0]       PIX_NEG  = 8'h00;
  localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_UNDEF  = {Q_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_ONE    = Q_W'(1 << FRAC_W);

  // ring slot of row (r's row + k - radius), k in 0..2*radius
  function automatic logic [RING_W-1:0] ring_add(input logic [RING_W-1:0] r, input int k);
    logic [RING_W+1:0] v;
    v = (RING_W+2)'(r) + (RING_W+2)'(k + RING_ROWS - WINDOW_RADIUS);
    if (v >= (RING_W+2)'(RING_ROWS)) v = v - (RING_W+2)'(RING_ROWS);
    if (v >= (RING_W+2)'(RING_ROWS)) v = v - (RING_W+2)'(RING_ROWS);
    return RING_W'(v);
  endfunction

  // saturating count step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

@@ sv/prs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; the top level sizes it from prs_pkg values.
module prs_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ sv/prs_div.sv @@
// Restoring divider for the Q2.16 ratios: q = (num*2^17 + den) / (2*den).
// Depends on prs_pkg. One quotient bit per cycle, Q_W quotient bits per division.
module prs_div import prs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] num,
  input  logic [CNT_W:0]   den,
  output logic             done,
  output logic [Q_W-1:0]   q
);
  localparam int DVD_W = CNT_W + FRAC_W + 2;
  localparam int DS_W  = CNT_W + 2;
  localparam int IT_W  = $clog2(Q_W + 1);

  logic [DVD_W-1:0] dvd;
  logic [DS_W-1:0]  rem;
  logic [DS_W-1:0]  ds;
  logic [Q_W-1:0]   low;
  logic [IT_W-1:0]  cnt;
  logic             active;
  logic [DS_W:0]    trial;

  // rounding bias folded into the dividend
  assign dvd   = (DVD_W'(num) << (FRAC_W + 1)) + DVD_W'(den);
  assign trial = {rem, low[Q_W-1]};
  assign q     = low;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem    <= DS_W'(dvd >> Q_W);
        low    <= dvd[Q_W-1:0];
        ds     <= DS_W'({den, 1'b0});
        cnt    <= IT_W'(Q_W);
        active <= 1'b1;
      end else if (active) begin
        // one quotient bit per step
        if (trial >= {1'b0, ds}) begin
          rem <= DS_W'(trial - {1'b0, ds});
          low <= {low[Q_W-2:0], 1'b1};
        end else begin
          rem <= trial[DS_W-1:0];
          low <= {low[Q_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == IT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

@@ sv/tolerant_precision_recall_scorer.sv @@
// Tolerant precision/recall scorer, top level. Depends on prs_pkg, prs_ram, prs_div.
// Throughput: one pixel per cycle; a pixel that completes row r >= 2 adds a sweep over
// the ring of line stores to classify row r-2, during which intake stalls.
// Frame end: a check state plus a sweep per remaining row, a last check, then each ratio
// on the shared divider (divider not used when undefined), and a load of the output
// register, which holds the result until taken.
// Reset: synchronous, clears counts and position; width 640, height 480. No clearing pass.
module tolerant_precision_recall_scorer import prs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [7:0] expected_pixel, [15:8] actual_pixel
  input  logic                 s_tlast,   // frame_end
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [22:0] true_positives, [45:23] false_positives, [68:46] true_negatives,
  // [91:69] false_negatives, [109:92] precision, [127:110] recall
  output logic [127:0]         m_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GEO_W-1:0]     cfg_data
);
  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ECHK = 3'd2;
  localparam logic [2:0] S_DP   = 3'd3;
  localparam logic [2:0] S_DPW  = 3'd4;
  localparam logic [2:0] S_DR   = 3'd5;
  localparam logic [2:0] S_DRW  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;
  localparam int R = WINDOW_RADIUS;

  logic [2:0]        state;
  logic [GEO_W-1:0]  frame_width, frame_height;
  logic [LW_W-1:0]   lat_w;
  logic [LH_W-1:0]   lat_h;
  logic              in_frame, full, end_pend;
  logic [ROW_W-1:0]  row, lim_row;
  logic [COL_W-1:0]  col, lim_col;
  logic [RING_W-1:0] ring, fin_ring;
  logic [LH_W-1:0]   fin_row;
  logic [CNT_W-1:0]  cnt_tp, cnt_fp, cnt_tn, cnt_fn;
  logic [SC_W-1:0]   scan_cnt, ps;
  logic              pv;
  logic [2*R-1:0]    expwin;
  logic [R-1:0]      actsh;
  logic [Q_W-1:0]    prec, rec;

  // intake view: geometry and position as they stand for this pixel
  logic [LW_W-1:0]   eff_w;
  logic [LH_W-1:0]   eff_h;
  logic [ROW_W-1:0]  eff_row;
  logic [COL_W-1:0]  eff_col;
  logic [RING_W-1:0] eff_ring, eff_fring;
  logic [LH_W-1:0]   eff_fin;
  logic              eff_full, col_last, row_last, accept, exp_pos, act_pos;

  always_comb begin
    if (in_frame) begin
      eff_w = lat_w;
      eff_h = lat_h;
    end else begin
      if (frame_width == '0)              eff_w = LW_W'(1);
      else if (frame_width > MAX_WIDTH)   eff_w = LW_W'(MAX_WIDTH);
      else                                eff_w = LW_W'(frame_width);
      if (frame_height == '0)             eff_h = LH_W'(1);
      else if (frame_height > MAX_HEIGHT) eff_h = LH_W'(MAX_HEIGHT);
      else                                eff_h = LH_W'(frame_height);
    end
    eff_row   = in_frame ? row : '0;
    eff_col   = in_frame ? col : '0;
    eff_ring  = in_frame ? ring : '0;
    eff_fin   = in_frame ? fin_row : '0;
    eff_fring = in_frame ? fin_ring : '0;
    eff_full  = in_frame && full;
    col_last  = (LW_W+1)'(eff_col) + 1'b1 >= (LW_W+1)'(eff_w);
    row_last  = (LH_W+1)'(eff_row) + 1'b1 >= (LH_W+1)'(eff_h);
  end

  assign s_tready  = (state == S_IN);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign exp_pos   = (s_tdata[7:0] == PIX_POS);
  assign act_pos   = (s_tdata[15:8] == PIX_POS);

  // line store banks, one per ring row
  logic [ENT_W-1:0] bank_q [RING_ROWS];
  for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
    prs_ram #(.DEPTH(MAX_WIDTH), .WIDTH(ENT_W)) u_ram (
      .clk  (clk),
      .we   (accept && !eff_full && (eff_ring == RING_W'(b))),
      .waddr(eff_col),
      .wdata({act_pos, exp_pos}),
      .raddr(scan_cnt[COL_W-1:0]),
      .rdata(bank_q[b])
    );
  end

  // column of the window at ps: expected positives present in rows f-R..f+R
  logic colexp, act_now, found;
  always_comb begin
    logic [RING_W-1:0]      bk;
    logic signed [NY_W-1:0] ny;
    logic                   pr;
    colexp  = 1'b0;
    act_now = 1'b0;
    for (int k = 0; k <= 2 * R; k++) begin
      bk = ring_add(fin_ring, k);
      ny = $signed(NY_W'(fin_row)) + $signed(NY_W'(k)) - $signed(NY_W'(R));
      pr = (ny >= 0) && (ny < $signed(NY_W'(lat_h))) && (ps < SC_W'(lat_w)) &&
           ((ny < $signed(NY_W'(lim_row))) ||
            ((ny == $signed(NY_W'(lim_row))) && (ps <= SC_W'(lim_col))));
      colexp = colexp | (pr & bank_q[bk][EXP_BIT]);
      if (k == R) act_now = pr & bank_q[bk][ACT_BIT];
    end
    found = |{expwin, colexp};
  end

  // shared divider
  logic             div_start, div_done;
  logic [Q_W-1:0]   div_q;
  logic [CNT_W:0]   den_p, den_r;
  assign den_p     = {1'b0, cnt_tp} + {1'b0, cnt_fp};
  assign den_r     = {1'b0, cnt_tp} + {1'b0, cnt_fn};
  assign div_start = ((state == S_DP) && (den_p != '0)) || ((state == S_DR) && (den_r != '0));

  prs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (cnt_tp),
    .den  ((state == S_DP) ? den_p : den_r),
    .done (div_done),
    .q    (div_q)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= GEO_W'(640);
      frame_height <= GEO_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WIDTH:  frame_width  <= cfg_data;
        CFG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IN;
      in_frame <= 1'b0;
      full     <= 1'b0;
      row      <= '0;
      col      <= '0;
      ring     <= '0;
      fin_row  <= '0;
      fin_ring <= '0;
      cnt_tp   <= '0;
      cnt_fp   <= '0;
      cnt_tn   <= '0;
      cnt_fn   <= '0;
      m_tvalid <= 1'b0;
      pv       <= 1'b0;
      end_pend <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_OUT)) m_tvalid <= 1'b0;
      unique case (state)
        S_IN: begin
          if (accept) begin
            lat_w    <= eff_w;
            lat_h    <= eff_h;
            in_frame <= 1'b1;
            end_pend <= s_tlast;
            if (eff_full) begin
              // overrun pixel: position and store untouched
              state   <= s_tlast ? S_ECHK : S_IN;
              lim_row <= ROW_W'(lat_h - 1'b1);
              lim_col <= COL_W'(lat_w - 1'b1);
            end else begin
              if (!act_pos) begin
                if (s_tdata[7:0] == PIX_NEG) cnt_tn <= sat_inc(cnt_tn);
                else                         cnt_fn <= sat_inc(cnt_fn);
              end
              lim_row <= eff_row;
              lim_col <= eff_col;
              if (col_last) begin
                col <= '0;
                if (row_last) begin
                  full <= 1'b1;
                  row  <= eff_row;
                  ring <= eff_ring;
                end else begin
                  full <= 1'b0;
                  row  <= eff_row + 1'b1;
                  ring <= ring_add(eff_ring, R + 1);
                end
                // classify the row that now has all rows below it
                if (eff_row >= ROW_W'(R)) begin
                  fin_row  <= LH_W'(eff_row - ROW_W'(R));
                  fin_ring <= ring_add(eff_ring, 0);
                  state    <= S_SCAN;
                  scan_cnt <= '0;
                  pv       <= 1'b0;
                  expwin   <= '0;
                  actsh    <= '0;
                end else begin
                  fin_row  <= eff_fin;
                  fin_ring <= eff_fring;
                  state    <= s_tlast ? S_ECHK : S_IN;
                end
              end else begin
                col      <= eff_col + 1'b1;
                row      <= eff_row;
                ring     <= eff_ring;
                full     <= 1'b0;
                fin_row  <= eff_fin;
                fin_ring <= eff_fring;
                state    <= s_tlast ? S_ECHK : S_IN;
              end
            end
          end
        end
        S_SCAN: begin
          // read issue
          if ((LW_W+1)'(scan_cnt) <= (LW_W+1)'(lat_w) + (LW_W+1)'(R - 1)) begin
            scan_cnt <= scan_cnt + 1'b1;
            ps       <= scan_cnt;
            pv       <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          // window update and decision for column ps - R
          if (pv) begin
            expwin <= (2*R)'({expwin, colexp});
            actsh  <= R'({actsh, act_now});
            if ((ps >= SC_W'(R)) && actsh[R-1]) begin
              if (found) cnt_tp <= sat_inc(cnt_tp);
              else       cnt_fp <= sat_inc(cnt_fp);
            end
            if ((LW_W+1)'(ps) == (LW_W+1)'(lat_w) + (LW_W+1)'(R - 1)) begin
              fin_row  <= fin_row + 1'b1;
              fin_ring <= ring_add(fin_ring, R + 1);
              state    <= end_pend ? S_ECHK : S_IN;
            end
          end
        end
        S_ECHK: begin
          if (fin_row <= LH_W'(lim_row)) begin
            state    <= S_SCAN;
            scan_cnt <= '0;
            pv       <= 1'b0;
            expwin   <= '0;
            actsh    <= '0;
          end else begin
            state <= S_DP;
          end
        end
        S_DP: begin
          if (den_p == '0) begin
            prec  <= Q_UNDEF;
            state <= S_DR;
          end else begin
            state <= S_DPW;
          end
        end
        S_DPW: begin
          if (div_done) begin
            prec  <= div_q;
            state <= S_DR;
          end
        end
        S_DR: begin
          if (den_r == '0) begin
            rec   <= Q_UNDEF;
            state <= S_OUT;
          end else begin
            state <= S_DRW;
          end
        end
        S_DRW: begin
          if (div_done) begin
            rec   <= div_q;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {rec, prec, cnt_fn, cnt_tn, cnt_fp, cnt_tp};
            m_tvalid <= 1'b1;
            cnt_tp   <= '0;
            cnt_fp   <= '0;
            cnt_tn   <= '0;
            cnt_fn   <= '0;
            in_frame <= 1'b0;
            full     <= 1'b0;
            row      <= '0;
            col      <= '0;
            ring     <= '0;
            fin_row  <= '0;
            fin_ring <= '0;
            end_pend <= 1'b0;
            state    <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

`ifndef SYNTHESIS
  // a sweep never targets a row past the last one received
  a_scan_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (fin_row <= LH_W'(lim_row)))
    else $error("sweep row beyond last received row");

  // ratios never exceed 1.0
  a_ratio: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (div_q <= Q_ONE))
    else $error("ratio above one");

  // a full frame sits on its last row
  a_full_row: assert property (@(posedge clk) disable iff (rst)
    (in_frame && full) |-> (LH_W'(row) == lat_h - 1'b1))
    else $error("frame full off last row");

  // sweep pipeline never runs past the window's right edge
  a_scan_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pv) |->
      ((LW_W+1)'(ps) <= (LW_W+1)'(lat_w) + (LW_W+1)'(R - 1)))
    else $error("sweep past row end");
`endif
endmodule
